[hdl/ptq_pkg.sv]
// ----------------------------------------------------------------------------
// ptq_pkg
// Shared types and constants for the periodic timer task queue: table depth,
// field widths, operation and status codes, table entry and result layouts.
// ----------------------------------------------------------------------------
`default_nettype none

package ptq_pkg;

  localparam int DEPTH      = 16;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int ID_W       = 16;
  localparam int TIME_W     = 32;
  localparam int IVAL_W     = 16;
  localparam int REMOVED_W  = 5;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_DELETE = 2'd1,
    OP_TICK   = 2'd2,
    OP_FLUSH  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DISPATCHED = 2'd0,
    ST_ADDED      = 2'd1,
    ST_DROPPED    = 2'd2,
    ST_DELETED    = 2'd3
  } status_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] due;
    logic [IVAL_W-1:0] ival;
  } entry_t;

  typedef struct packed {
    status_t                status;
    logic [ID_W-1:0]        id;
    logic [REMOVED_W-1:0]   removed;
    logic                   last;
  } rsp_t;

  // removal count as reported, saturating at the field maximum
  function automatic logic [REMOVED_W-1:0] sat_count(input logic [CNT_W-1:0] c);
    logic [7:0] c8;
    c8 = 8'(c);
    return (c8 > 8'd31) ? 5'd31 : c8[REMOVED_W-1:0];
  endfunction

endpackage

`default_nettype wire

[hdl/ptq_cmd_if.sv]
// ----------------------------------------------------------------------------
// ptq_cmd_if
// Command channel of the timer task queue: valid/ready plus one command.
// ----------------------------------------------------------------------------
`default_nettype none

interface ptq_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    op;
  logic [ptq_pkg::ID_W-1:0]      command_id;
  logic [ptq_pkg::TIME_W-1:0]    due_time;
  logic [ptq_pkg::IVAL_W-1:0]    repeat_interval;
  logic [ptq_pkg::TIME_W-1:0]    current_time;

  modport source (
    output valid, op, command_id, due_time, repeat_interval, current_time,
    input  ready
  );
  modport sink (
    input  valid, op, command_id, due_time, repeat_interval, current_time,
    output ready
  );
endinterface

`default_nettype wire

[hdl/ptq_rsp_if.sv]
// ----------------------------------------------------------------------------
// ptq_rsp_if
// Result channel of the timer task queue: valid/ready plus one result.
// ----------------------------------------------------------------------------
`default_nettype none

interface ptq_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      status;
  logic [ptq_pkg::ID_W-1:0]        dispatched_id;
  logic [ptq_pkg::REMOVED_W-1:0]   removed_count;
  logic                            last;

  modport source (
    output valid, status, dispatched_id, removed_count, last,
    input  ready
  );
  modport sink (
    input  valid, status, dispatched_id, removed_count, last,
    output ready
  );
endinterface

`default_nettype wire

[hdl/periodic_timer_task_queue_unit.sv]
// ----------------------------------------------------------------------------
// periodic_timer_task_queue_unit
// Sorted timer queue: a table of tasks kept in due-time order, walked one
// entry per cycle by a small sequencer around one shared time comparator.
// ----------------------------------------------------------------------------
//   port  dir   handshake     carries
//   cmd   sink  valid/ready   op, command_id, due_time, repeat_interval,
//                             current_time
//   rsp   src   valid/ready   status, dispatched_id, removed_count, last
//
// One command at a time; cmd.ready is high only while the sequencer idles.
// Add scans for its slot and then inserts; delete compacts the table; flush
// walks it. A tick first counts the due tasks, then per dispatched task pops
// it and, for a repeating task, sums its new due time and reinserts it.
// Reset empties the table at once; entry contents are never cleared.
// The sequencer holds whenever a result is due and the rsp register is full.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_timer_task_queue_unit (
  input  logic      clk,
  input  logic      rst,
  ptq_cmd_if.sink   cmd,
  ptq_rsp_if.source rsp
);

  typedef enum logic [9:0] {
    S_IDLE      = 10'b00_0000_0001,
    S_INS_SCAN  = 10'b00_0000_0010,
    S_INS       = 10'b00_0000_0100,
    S_DEL       = 10'b00_0000_1000,
    S_TICK_CNT  = 10'b00_0001_0000,
    S_TICK_POP  = 10'b00_0010_0000,
    S_TICK_SUM  = 10'b00_0100_0000,
    S_FLUSH     = 10'b00_1000_0000,
    S_RESULT    = 10'b01_0000_0000,
    S_RSVD      = 10'b10_0000_0000
  } state_t;

  state_t                          state;
  ptq_pkg::entry_t                 ent [ptq_pkg::DEPTH];
  logic [ptq_pkg::CNT_W-1:0]       count;
  logic [ptq_pkg::CNT_W-1:0]       p;
  logic [ptq_pkg::CNT_W-1:0]       w;
  logic [ptq_pkg::CNT_W-1:0]       rem;
  logic [ptq_pkg::CNT_W-1:0]       removed;
  logic [ptq_pkg::TIME_W-1:0]      key;
  logic [ptq_pkg::TIME_W-1:0]      now_r;
  logic [ptq_pkg::ID_W-1:0]        nid;
  logic [ptq_pkg::IVAL_W-1:0]      niv;
  ptq_pkg::op_t                    op_r;
  ptq_pkg::status_t                res_status;
  logic [ptq_pkg::REMOVED_W-1:0]   res_cnt;
  logic                            pend_v;
  logic [ptq_pkg::ID_W-1:0]        pend_id;
  logic                            rsp_valid;
  ptq_pkg::rsp_t                   rsp_q;

  ptq_pkg::entry_t                 rd;
  logic                            in_range;
  logic                            due_le;
  logic                            out_free;
  logic                            rsp_load;
  logic [ptq_pkg::TIME_W:0]        sum;

  assign rd       = ent[p[ptq_pkg::IDX_W-1:0]];
  assign in_range = (p < count);
  assign due_le   = (rd.due <= key);
  assign out_free = !rsp_valid || rsp.ready;
  assign sum      = {1'b0, now_r} + {{(ptq_pkg::TIME_W + 1 - ptq_pkg::IVAL_W){1'b0}}, niv};

  // cycles in which the result register takes a new result
  assign rsp_load = out_free &&
                    ((state == S_TICK_POP) || (state == S_RESULT) ||
                     (state == S_FLUSH && pend_v && (!in_range || rd.due == '0)));

  assign cmd.ready         = (state == S_IDLE);
  assign rsp.valid         = rsp_valid;
  assign rsp.status        = rsp_q.status;
  assign rsp.dispatched_id = rsp_q.id;
  assign rsp.removed_count = rsp_q.removed;
  assign rsp.last          = rsp_q.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
      pend_v    <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            op_r  <= ptq_pkg::op_t'(cmd.op);
            nid   <= cmd.command_id;
            niv   <= cmd.repeat_interval;
            now_r <= cmd.current_time;
            p     <= '0;
            w     <= '0;
            removed <= '0;
            pend_v  <= 1'b0;
            unique case (ptq_pkg::op_t'(cmd.op))
              ptq_pkg::OP_ADD: begin
                key <= cmd.due_time;
                if (count == ptq_pkg::CNT_W'(ptq_pkg::DEPTH)) begin
                  res_status <= ptq_pkg::ST_DROPPED;
                  res_cnt    <= '0;
                  state      <= S_RESULT;
                end else begin
                  state <= S_INS_SCAN;
                end
              end
              ptq_pkg::OP_DELETE: state <= S_DEL;
              ptq_pkg::OP_TICK: begin
                key   <= cmd.current_time;
                state <= S_TICK_CNT;
              end
              ptq_pkg::OP_FLUSH: state <= S_FLUSH;
              default: state <= S_IDLE;
            endcase
          end
        end

        // find the slot after every entry due at or before key
        S_INS_SCAN: begin
          if (in_range && due_le) begin
            p <= p + 1'b1;
          end else begin
            state <= S_INS;
          end
        end

        S_INS: begin
          for (int i = 1; i < ptq_pkg::DEPTH; i++) begin
            if (ptq_pkg::CNT_W'(i) > p) begin
              ent[i] <= ent[i-1];
            end else if (ptq_pkg::CNT_W'(i) == p) begin
              ent[i] <= '{id: nid, due: key, ival: niv};
            end
          end
          if (p == '0) begin
            ent[0] <= '{id: nid, due: key, ival: niv};
          end
          count <= count + 1'b1;
          if (op_r == ptq_pkg::OP_ADD) begin
            res_status <= ptq_pkg::ST_ADDED;
            res_cnt    <= '0;
            state      <= S_RESULT;
          end else if (rem == '0) begin
            state <= S_IDLE;
          end else begin
            state <= S_TICK_POP;
          end
        end

        // compaction: p reads, w writes the survivors
        S_DEL: begin
          if (in_range) begin
            if (rd.id == nid && rd.ival == niv) begin
              removed <= removed + 1'b1;
            end else begin
              ent[w[ptq_pkg::IDX_W-1:0]] <= rd;
              w <= w + 1'b1;
            end
            p <= p + 1'b1;
          end else begin
            count      <= w;
            res_status <= ptq_pkg::ST_DELETED;
            res_cnt    <= ptq_pkg::sat_count(removed);
            state      <= S_RESULT;
          end
        end

        // count the due prefix at tick start
        S_TICK_CNT: begin
          if (in_range && due_le) begin
            p <= p + 1'b1;
          end else if (p == '0) begin
            state <= S_IDLE;
          end else begin
            rem   <= p;
            state <= S_TICK_POP;
          end
        end

        S_TICK_POP: begin
          if (out_free) begin
            rsp_q     <= '{status: ptq_pkg::ST_DISPATCHED, id: ent[0].id,
                           removed: '0, last: (rem == ptq_pkg::CNT_W'(1))};
            for (int i = 0; i < ptq_pkg::DEPTH - 1; i++) begin
              ent[i] <= ent[i+1];
            end
            count <= count - 1'b1;
            rem   <= rem - 1'b1;
            nid   <= ent[0].id;
            niv   <= ent[0].ival;
            if (ent[0].ival != '0) begin
              state <= S_TICK_SUM;
            end else if (rem == ptq_pkg::CNT_W'(1)) begin
              state <= S_IDLE;
            end
          end
        end

        // reschedule time, saturating at the top of the time range
        S_TICK_SUM: begin
          key   <= sum[ptq_pkg::TIME_W] ? '1 : sum[ptq_pkg::TIME_W-1:0];
          p     <= '0;
          state <= S_INS_SCAN;
        end

        // one match held back so the final one can carry last
        S_FLUSH: begin
          if (in_range) begin
            if (rd.due == '0) begin
              if (!pend_v || out_free) begin
                if (pend_v) begin
                  rsp_q     <= '{status: ptq_pkg::ST_DISPATCHED, id: pend_id,
                                 removed: '0, last: 1'b0};
                end
                pend_id <= rd.id;
                pend_v  <= 1'b1;
                p       <= p + 1'b1;
              end
            end else begin
              p <= p + 1'b1;
            end
          end else begin
            count <= '0;
            if (!pend_v) begin
              state <= S_IDLE;
            end else if (out_free) begin
              rsp_q     <= '{status: ptq_pkg::ST_DISPATCHED, id: pend_id,
                             removed: '0, last: 1'b1};
              pend_v    <= 1'b0;
              state     <= S_IDLE;
            end
          end
        end

        S_RESULT: begin
          if (out_free) begin
            rsp_q     <= '{status: res_status, id: '0, removed: res_cnt, last: 1'b1};
            state     <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
